// ----- sv/lzss_stream_decoder_core_assert.svh -----
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef LZSS_STREAM_DECODER_CORE_ASSERT_SVH
`define LZSS_STREAM_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lzsd_pkg.sv -----
package lzsd_pkg;

  // Token geometry
  localparam int POS_BITS    = 13;
  localparam int LEN_BITS    = 4;
  localparam int LIT_BITS    = 8;
  localparam int TOK_BITS    = 1 + POS_BITS + LEN_BITS;
  localparam int LIT_PHASE   = 1 + LIT_BITS;
  localparam int POS_PHASE   = 1 + POS_BITS;
  localparam int MATCH_PHASE = TOK_BITS;
  localparam int PHASE_W     = $clog2(MATCH_PHASE + 1);
  localparam int BCNT_W      = $clog2(LIT_BITS + 1);

  // Match copy
  localparam int MIN_MATCH   = 3;
  localparam int CNT_W       = LEN_BITS + 1;

  // Window and checksum
  localparam int WIN_DEPTH   = 1 << POS_BITS;
  localparam int SUM_W       = 32;

  typedef enum logic [1:0] {
    EVT_NONE,
    EVT_LIT,
    EVT_END,
    EVT_MATCH
  } tok_evt_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clr;
  } tok_ctrl_t;

  typedef struct packed {
    tok_evt_t              evt;
    logic                  more;
    logic [LIT_BITS-1:0]   lit;
    logic [POS_BITS-1:0]   pos;
    logic [LEN_BITS-1:0]   code;
  } tok_status_t;

  typedef struct packed {
    logic                  wr_en;
    logic [LIT_BITS-1:0]   wr_data;
    logic                  rd_en;
    logic [POS_BITS-1:0]   rd_addr;
  } win_req_t;

endpackage

// ----- sv/lzsd_if.sv -----
// Compressed byte channel
interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Decoded result channel
interface lzsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;
  logic       stream_done;
  logic       sum_ok;

  modport source (output valid, output out_byte, output has_byte, output last,
                  output stream_done, output sum_ok, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last,
                  input stream_done, input sum_ok, output ready);
endinterface

// ----- sv/lzsd_token.sv -----
`include "lzss_stream_decoder_core_assert.svh"

module lzsd_token (
  input  logic                  clk,
  input  logic                  rst,
  input  lzsd_pkg::tok_ctrl_t   ctrl,
  input  logic [7:0]            in_byte,
  output lzsd_pkg::tok_status_t status
);

  logic [lzsd_pkg::LIT_BITS-1:0] sh;
  logic [lzsd_pkg::BCNT_W-1:0]   nbits;
  logic [lzsd_pkg::TOK_BITS-1:0] tok;
  logic [lzsd_pkg::PHASE_W-1:0]  phase;
  logic                          flag;

  // Shift one stream bit per step into the token
  always_ff @(posedge clk) begin
    if (rst) begin
      nbits <= '0;
      tok   <= '0;
      phase <= '0;
      flag  <= 1'b0;
    end else begin
      if (ctrl.load) begin
        sh    <= in_byte;
        nbits <= lzsd_pkg::BCNT_W'(lzsd_pkg::LIT_BITS);
      end else if (ctrl.step) begin
        sh    <= {sh[lzsd_pkg::LIT_BITS-2:0], 1'b0};
        nbits <= nbits - 1'b1;
        tok   <= {tok[lzsd_pkg::TOK_BITS-2:0], sh[lzsd_pkg::LIT_BITS-1]};
        phase <= phase + 1'b1;
        if (phase == '0) begin
          flag <= sh[lzsd_pkg::LIT_BITS-1];
        end
      end
      if (ctrl.clr) begin
        tok   <= '0;
        phase <= '0;
      end
    end
  end

  // Classify the token seen so far
  always_comb begin
    status.evt  = lzsd_pkg::EVT_NONE;
    status.more = (nbits != '0);
    status.lit  = tok[lzsd_pkg::LIT_BITS-1:0];
    status.pos  = tok[lzsd_pkg::LEN_BITS +: lzsd_pkg::POS_BITS];
    status.code = tok[lzsd_pkg::LEN_BITS-1:0];
    if (flag && phase == lzsd_pkg::PHASE_W'(lzsd_pkg::LIT_PHASE)) begin
      status.evt = lzsd_pkg::EVT_LIT;
    end else if (!flag && phase == lzsd_pkg::PHASE_W'(lzsd_pkg::POS_PHASE) &&
                 tok[lzsd_pkg::POS_BITS-1:0] == '0) begin
      status.evt = lzsd_pkg::EVT_END;
    end else if (!flag && phase == lzsd_pkg::PHASE_W'(lzsd_pkg::MATCH_PHASE)) begin
      status.evt = lzsd_pkg::EVT_MATCH;
    end
  end

  `LZSD_ASSERT_NOW(a_phase_bound, 1'b1, phase <= lzsd_pkg::PHASE_W'(lzsd_pkg::MATCH_PHASE), "token phase past match length")
  `LZSD_ASSERT_NOW(a_lit_bound, flag, phase <= lzsd_pkg::PHASE_W'(lzsd_pkg::LIT_PHASE), "literal token not closed")
  `LZSD_ASSERT_NOW(a_step_bits, ctrl.step, nbits != '0, "bit step with no bits left")

endmodule

// ----- sv/lzsd_window.sv -----
module lzsd_window (
  input  logic                          clk,
  input  logic                          rst,
  input  lzsd_pkg::win_req_t            req,
  output logic [lzsd_pkg::LIT_BITS-1:0] rd_byte
);

  logic [lzsd_pkg::LIT_BITS-1:0] mem [lzsd_pkg::WIN_DEPTH];
  logic [lzsd_pkg::LIT_BITS-1:0] rdata;
  logic                          rd_ok;
  logic [lzsd_pkg::POS_BITS-1:0] wp;
  logic                          wrapped;
  logic                          zero_written;
  logic                          written;

  // Entries fill upward from one; unwritten entries read as zero
  assign written = zero_written ||
                   (req.rd_addr != '0 && (wrapped || req.rd_addr < wp));

  // Track the write pointer and how far the window has filled
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= lzsd_pkg::POS_BITS'(1);
      wrapped      <= 1'b0;
      zero_written <= 1'b0;
    end else if (req.wr_en) begin
      wp <= wp + 1'b1;
      if (wp == '1) begin
        wrapped <= 1'b1;
      end
      if (wp == '0) begin
        zero_written <= 1'b1;
      end
    end
  end

  // Window storage with separate write and registered read ports
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
      rd_ok <= written;
    end
  end

  assign rd_byte = rd_ok ? rdata : '0;

endmodule

// ----- sv/lzss_stream_decoder_core.sv -----
// LZSS stream decoder, 8 KiB window. Takes one compressed byte per transfer and
// walks its bits one per cycle through the token shifter between token events.
// A byte that only extends a token passes through accept, eight bit steps and
// the return to idle. A literal or end marker adds an event step; a match adds
// an event step plus a window read and write per copied byte (3 to 18 bytes),
// since each copy reads then writes the history window; output back-pressure
// adds to these. After reset the window reads as zero without a clearing pass:
// a fill tracker masks entries not yet written. After the end marker is decoded
// the block takes and drops every further byte until reset.
`include "lzss_stream_decoder_core_assert.svh"

module lzss_stream_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lzsd_pkg::SUM_W-1:0]    cfg_wr_data,
  lzsd_in_if.sink                       in_stream,
  lzsd_out_if.source                    out_stream
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARSE,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [lzsd_pkg::SUM_W-1:0]      expected_sum;
  logic [lzsd_pkg::SUM_W-1:0]      byte_sum;
  logic [lzsd_pkg::POS_BITS-1:0]   cp_pos;
  logic [lzsd_pkg::CNT_W-1:0]      cp_cnt;
  logic                            out_valid;
  logic [lzsd_pkg::LIT_BITS-1:0]   out_byte;
  logic                            has_byte;
  logic                            last;
  logic                            stream_done;
  logic                            sum_ok;

  logic                            out_free;
  logic                            out_load;
  logic [lzsd_pkg::LIT_BITS-1:0]   byte_next;
  logic                            has_next;
  logic                            last_next;
  logic                            ok_next;
  logic                            cp_start;
  logic                            cp_adv;
  logic                            in_take;

  lzsd_pkg::tok_ctrl_t             tctrl;
  lzsd_pkg::tok_status_t           tstat;
  lzsd_pkg::win_req_t              wreq;
  logic [lzsd_pkg::LIT_BITS-1:0]   win_byte;

  lzsd_token u_token (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tctrl),
    .in_byte (in_stream.in_byte),
    .status  (tstat)
  );

  lzsd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .req     (wreq),
    .rd_byte (win_byte)
  );

  assign out_free        = !out_valid || out_stream.ready;
  assign in_stream.ready = (state == S_IDLE) || (state == S_DONE);
  assign in_take         = in_stream.valid && (state == S_IDLE);

  // Sequence bit steps, token events and match copies
  always_comb begin
    state_next   = state;
    tctrl        = '0;
    wreq         = '0;
    wreq.rd_addr = cp_pos;
    out_load     = 1'b0;
    byte_next    = tstat.lit;
    has_next     = 1'b1;
    last_next    = 1'b1;
    ok_next      = 1'b0;
    cp_start     = 1'b0;
    cp_adv       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_stream.valid) begin
          tctrl.load = 1'b1;
          state_next = S_PARSE;
        end
      end
      S_PARSE: begin
        case (tstat.evt)
          lzsd_pkg::EVT_LIT: begin
            if (out_free) begin
              out_load     = 1'b1;
              wreq.wr_en   = 1'b1;
              wreq.wr_data = tstat.lit;
              tctrl.clr    = 1'b1;
            end
          end
          lzsd_pkg::EVT_END: begin
            if (out_free) begin
              out_load   = 1'b1;
              byte_next  = '0;
              has_next   = 1'b0;
              ok_next    = (byte_sum == expected_sum);
              tctrl.clr  = 1'b1;
              state_next = S_DONE;
            end
          end
          lzsd_pkg::EVT_MATCH: begin
            cp_start   = 1'b1;
            tctrl.clr  = 1'b1;
            state_next = S_COPY_RD;
          end
          default: begin
            if (tstat.more) begin
              tctrl.step = 1'b1;
            end else begin
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_COPY_RD: begin
        wreq.rd_en = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        byte_next = win_byte;
        last_next = (cp_cnt == lzsd_pkg::CNT_W'(1));
        if (out_free) begin
          out_load     = 1'b1;
          wreq.wr_en   = 1'b1;
          wreq.wr_data = win_byte;
          cp_adv       = 1'b1;
          state_next   = (cp_cnt == lzsd_pkg::CNT_W'(1)) ? S_PARSE : S_COPY_RD;
        end
      end
      S_DONE: begin
        state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, sums, copy cursor and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      expected_sum <= '0;
      byte_sum     <= '0;
      cp_cnt       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        expected_sum <= cfg_wr_data;
      end
      if (in_take) begin
        byte_sum <= byte_sum + lzsd_pkg::SUM_W'(in_stream.in_byte);
      end
      if (cp_start) begin
        cp_pos <= tstat.pos;
        cp_cnt <= lzsd_pkg::CNT_W'(tstat.code) + lzsd_pkg::CNT_W'(lzsd_pkg::MIN_MATCH);
      end else if (cp_adv) begin
        cp_pos <= cp_pos + 1'b1;
        cp_cnt <= cp_cnt - 1'b1;
      end
      if (out_load) begin
        out_valid   <= 1'b1;
        out_byte    <= byte_next;
        has_byte    <= has_next;
        last        <= last_next;
        stream_done <= !has_next;
        sum_ok      <= ok_next;
      end else if (out_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_stream.valid       = out_valid;
  assign out_stream.out_byte    = out_byte;
  assign out_stream.has_byte    = has_byte;
  assign out_stream.last        = last;
  assign out_stream.stream_done = stream_done;
  assign out_stream.sum_ok      = sum_ok;

  `LZSD_ASSERT_NOW(a_wr_with_out, wreq.wr_en, out_load && has_next, "window write without decoded byte transfer")
  `LZSD_ASSERT_NEXT(a_end_done, out_load && !has_next, state == S_DONE, "end report not followed by done")
  `LZSD_ASSERT_NOW(a_copy_cnt, state == S_COPY_WR || state == S_COPY_RD, cp_cnt != '0, "copy running with zero count")

endmodule
